FILE: src/ppmsp_pkg.sv
// Shared types and constants for the PPM image stream parser.
package ppmsp_pkg;

    // Kind of result item.
    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_PIXEL  = 2'd1,
        KIND_BAD    = 2'd2,
        KIND_END    = 2'd3
    } kind_t;

    localparam logic [7:0] CHAR_P     = 8'h50;
    localparam logic [7:0] CHAR_3     = 8'h33;
    localparam logic [7:0] CHAR_6     = 8'h36;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    localparam logic [1:0] TOKEN_CHARS_MAX = 2'd3;

    // One result transaction.
    typedef struct packed {
        kind_t       kind;
        logic [9:0]  width;
        logic [9:0]  height;
        logic [9:0]  max_color;
        logic        binary_format;
        logic [23:0] pixel_rgb;
        logic        final_res;
    } res_t;

    function automatic logic is_sep(input logic [7:0] b);
        return (b == CHAR_SPACE) || (b == CHAR_LF) || (b == CHAR_CR);
    endfunction

endpackage

FILE: src/ppm_image_stream_parser.sv
// PPM (P3/P6) byte stream parser producing header and pixel transactions.
// A result is registered in the output register, or in the skid stage while the output is stalled.
// Throughput: one byte per cycle while byte_stall is low; the header checks, the token times-ten
// update and the pixel packing all sit between the byte port and the result register.
// With the output stalled, bytes keep flowing until a second result waits in the skid stage.
// Reset (rst_n low, asynchronous) returns the parser to expecting the magic 'P' and clears all.
module ppm_image_stream_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  byte_value,
    input  logic        last_byte,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [1:0]  kind,
    output logic [9:0]  width,
    output logic [9:0]  height,
    output logic [9:0]  max_color,
    output logic        binary_format,
    output logic [23:0] pixel_rgb,
    output logic        final_res
);

    typedef enum logic [2:0] {
        PH_MAGIC_P   = 3'd0,
        PH_MAGIC_D   = 3'd1,
        PH_MAGIC_SEP = 3'd2,
        PH_HEADER    = 3'd3,
        PH_SKIP      = 3'd4,
        PH_RAW       = 3'd5,
        PH_ASCII     = 3'd6,
        PH_IDLE      = 3'd7
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        binary_mode_reg, binary_mode_next;
    logic [9:0]  token_value_reg, token_value_next;
    logic [1:0]  token_chars_reg, token_chars_next;
    logic        in_token_reg, in_token_next;
    logic        digits_stopped_reg, digits_stopped_next;
    logic [1:0]  field_index_reg, field_index_next;
    logic [7:0]  red_hold_reg, red_hold_next;
    logic [7:0]  green_hold_reg, green_hold_next;
    logic [9:0]  width_reg, width_next;
    logic [9:0]  height_reg, height_next;
    logic [9:0]  maxcolor_reg, maxcolor_next;

    ppmsp_pkg::res_t out_reg;
    ppmsp_pkg::res_t skid_reg;
    ppmsp_pkg::res_t res_new;
    logic            out_valid_reg;
    logic            skid_valid_reg;

    logic accept;
    logic out_take;
    logic sep;
    logic is_digit;

    // Token character update, as if the byte were appended to the current token.
    logic [9:0]  base_val;
    logic [1:0]  base_chars;
    logic        base_stop;
    logic [12:0] val_times_ten;
    logic [9:0]  add_val;
    logic [1:0]  add_chars;
    logic        add_stop;

    logic        have;
    ppmsp_pkg::kind_t res_kind;
    logic [23:0] rgb;
    logic        close_hdr;
    logic        close_comp;
    logic [9:0]  close_val;

    assign accept     = byte_valid && !skid_valid_reg;
    assign byte_stall = skid_valid_reg;
    assign out_take   = out_valid_reg && !res_stall;
    assign sep        = ppmsp_pkg::is_sep(byte_value);
    assign is_digit   = (byte_value >= ppmsp_pkg::CHAR_0) && (byte_value <= ppmsp_pkg::CHAR_9);

    always_comb
    begin
        base_val      = in_token_reg ? token_value_reg : 10'd0;
        base_chars    = in_token_reg ? token_chars_reg : 2'd0;
        base_stop     = in_token_reg ? digits_stopped_reg : 1'b0;
        val_times_ten = {base_val, 3'b000} + {2'b00, base_val, 1'b0}
                        + {9'd0, 4'(byte_value - ppmsp_pkg::CHAR_0)};
        add_val       = base_val;
        add_chars     = base_chars;
        add_stop      = base_stop;
        if (base_chars < ppmsp_pkg::TOKEN_CHARS_MAX)
        begin
            if (!base_stop && is_digit)
                add_val = val_times_ten[9:0];
            else
                add_stop = 1'b1;
            add_chars = base_chars + 2'd1;
        end
    end

    always_comb
    begin
        phase_next          = phase_reg;
        binary_mode_next    = binary_mode_reg;
        token_value_next    = token_value_reg;
        token_chars_next    = token_chars_reg;
        in_token_next       = in_token_reg;
        digits_stopped_next = digits_stopped_reg;
        field_index_next    = field_index_reg;
        red_hold_next       = red_hold_reg;
        green_hold_next     = green_hold_reg;
        width_next          = width_reg;
        height_next         = height_reg;
        maxcolor_next       = maxcolor_reg;
        have       = 1'b0;
        res_kind   = ppmsp_pkg::KIND_END;
        rgb        = 24'd0;
        close_hdr  = 1'b0;
        close_comp = 1'b0;
        close_val  = token_value_reg;

        unique case (phase_reg)
            PH_MAGIC_P:
            begin
                if (byte_value == ppmsp_pkg::CHAR_P && !last_byte)
                    phase_next = PH_MAGIC_D;
                else
                begin
                    have = 1'b1;
                    res_kind = ppmsp_pkg::KIND_BAD;
                    phase_next = PH_IDLE;
                end
            end
            PH_MAGIC_D:
            begin
                if ((byte_value == ppmsp_pkg::CHAR_3 || byte_value == ppmsp_pkg::CHAR_6)
                    && !last_byte)
                begin
                    binary_mode_next = (byte_value == ppmsp_pkg::CHAR_6);
                    phase_next = PH_MAGIC_SEP;
                end
                else
                begin
                    have = 1'b1;
                    res_kind = ppmsp_pkg::KIND_BAD;
                    phase_next = PH_IDLE;
                end
            end
            PH_MAGIC_SEP:
            begin
                if (sep && !last_byte)
                    phase_next = PH_HEADER;
                else
                begin
                    have = 1'b1;
                    res_kind = ppmsp_pkg::KIND_BAD;
                    phase_next = PH_IDLE;
                end
            end
            PH_HEADER, PH_ASCII:
            begin
                if (sep)
                begin
                    close_val = token_value_reg;
                    if (in_token_reg)
                    begin
                        close_hdr  = (phase_reg == PH_HEADER);
                        close_comp = (phase_reg == PH_ASCII);
                    end
                end
                else
                begin
                    in_token_next       = 1'b1;
                    token_value_next    = add_val;
                    token_chars_next    = add_chars;
                    digits_stopped_next = add_stop;
                    close_val = add_val;
                    if (last_byte)
                    begin
                        close_hdr  = (phase_reg == PH_HEADER);
                        close_comp = (phase_reg == PH_ASCII);
                    end
                end
            end
            PH_SKIP:
            begin
                if (!sep)
                begin
                    red_hold_next = byte_value;
                    field_index_next = 2'd1;
                    phase_next = PH_RAW;
                end
            end
            PH_RAW:
            begin
                if (field_index_reg == 2'd1)
                begin
                    green_hold_next = byte_value;
                    field_index_next = 2'd2;
                end
                else
                begin
                    rgb = {red_hold_reg, green_hold_reg, byte_value};
                    field_index_next = 2'd0;
                    have = 1'b1;
                    res_kind = ppmsp_pkg::KIND_PIXEL;
                end
            end
            PH_IDLE:
            begin
            end
            default:
            begin
            end
        endcase

        // Closing a header token stores it; the third one completes the header.
        if (close_hdr)
        begin
            in_token_next = 1'b0;
            unique case (field_index_reg)
                2'd0:    width_next = close_val;
                2'd1:    height_next = close_val;
                default: maxcolor_next = close_val;
            endcase
            if (field_index_reg >= 2'd2)
            begin
                field_index_next = 2'd0;
                phase_next = binary_mode_reg ? PH_SKIP : PH_ASCII;
                have = 1'b1;
                res_kind = ppmsp_pkg::KIND_HEADER;
            end
            else
                field_index_next = field_index_reg + 2'd1;
        end

        if (close_comp)
        begin
            in_token_next = 1'b0;
            unique case (field_index_reg)
                2'd0:
                begin
                    red_hold_next = close_val[7:0];
                    field_index_next = 2'd1;
                end
                2'd1:
                begin
                    green_hold_next = close_val[7:0];
                    field_index_next = 2'd2;
                end
                default:
                begin
                    field_index_next = 2'd0;
                    rgb = {red_hold_reg, green_hold_reg, close_val[7:0]};
                    have = 1'b1;
                    res_kind = ppmsp_pkg::KIND_PIXEL;
                end
            endcase
        end

        // An ASCII file that ends mid-pixel still emits it, missing components zero.
        if (phase_reg == PH_ASCII && last_byte && !have && field_index_next != 2'd0)
        begin
            rgb = {red_hold_next,
                   (field_index_next == 2'd2) ? green_hold_next : 8'd0,
                   8'd0};
            have = 1'b1;
            res_kind = ppmsp_pkg::KIND_PIXEL;
        end

        if (last_byte && !have)
        begin
            have = 1'b1;
            res_kind = ppmsp_pkg::KIND_END;
        end

        res_new.kind          = res_kind;
        res_new.width         = width_next;
        res_new.height        = height_next;
        res_new.max_color     = maxcolor_next;
        res_new.binary_format = binary_mode_next;
        res_new.pixel_rgb     = (res_kind == ppmsp_pkg::KIND_PIXEL) ? rgb : 24'd0;
        res_new.final_res     = last_byte;

        // The last byte of a file leaves the parser ready for the next file.
        if (last_byte)
        begin
            phase_next          = PH_MAGIC_P;
            binary_mode_next    = 1'b0;
            token_value_next    = 10'd0;
            token_chars_next    = 2'd0;
            in_token_next       = 1'b0;
            digits_stopped_next = 1'b0;
            field_index_next    = 2'd0;
            red_hold_next       = 8'd0;
            green_hold_next     = 8'd0;
            width_next          = 10'd0;
            height_next         = 10'd0;
            maxcolor_next       = 10'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_MAGIC_P;
            binary_mode_reg    <= 1'b0;
            token_value_reg    <= 10'd0;
            token_chars_reg    <= 2'd0;
            in_token_reg       <= 1'b0;
            digits_stopped_reg <= 1'b0;
            field_index_reg    <= 2'd0;
            red_hold_reg       <= 8'd0;
            green_hold_reg     <= 8'd0;
            width_reg          <= 10'd0;
            height_reg         <= 10'd0;
            maxcolor_reg       <= 10'd0;
            out_valid_reg      <= 1'b0;
            skid_valid_reg     <= 1'b0;
            out_reg            <= '0;
            skid_reg           <= '0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg          <= phase_next;
                binary_mode_reg    <= binary_mode_next;
                token_value_reg    <= token_value_next;
                token_chars_reg    <= token_chars_next;
                in_token_reg       <= in_token_next;
                digits_stopped_reg <= digits_stopped_next;
                field_index_reg    <= field_index_next;
                red_hold_reg       <= red_hold_next;
                green_hold_reg     <= green_hold_next;
                width_reg          <= width_next;
                height_reg         <= height_next;
                maxcolor_reg       <= maxcolor_next;
            end

            if (!out_valid_reg || out_take)
            begin
                // Skid entry is older than any new result, so it goes out first.
                if (skid_valid_reg)
                begin
                    out_reg        <= skid_reg;
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else if (accept && have)
                begin
                    out_reg       <= res_new;
                    out_valid_reg <= 1'b1;
                end
                else
                    out_valid_reg <= 1'b0;
            end
            else if (accept && have)
            begin
                skid_reg       <= res_new;
                skid_valid_reg <= 1'b1;
            end
        end
    end

    assign res_valid     = out_valid_reg;
    assign kind          = out_reg.kind;
    assign width         = out_reg.width;
    assign height        = out_reg.height;
    assign max_color     = out_reg.max_color;
    assign binary_format = out_reg.binary_format;
    assign pixel_rgb     = out_reg.pixel_rgb;
    assign final_res     = out_reg.final_res;

    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register is empty");

    a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && res_stall))
        else $error("skid entry filled while output was not stalled");

    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_byte) |=> (phase_reg == PH_MAGIC_P && field_index_reg == 2'd0))
        else $error("parser did not return to magic check after last byte");

    a_pixel_only_rgb: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && out_reg.kind != ppmsp_pkg::KIND_PIXEL) |-> (pixel_rgb == 24'd0))
        else $error("nonzero pixel data on a non-pixel result");

endmodule
